>>> rtl/wwgs_pkg.sv
// Shared types and constants for the Wireworld grid stepper.
// Used by the channel interfaces, the window module, the top level and the checker.
// No dependencies.
package wwgs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 6;
    localparam int STATE_W = 2;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_IDX_W  = $clog2(GRID_WIDTH);
    localparam int ROW_IDX_W  = $clog2(GRID_HEIGHT);

    // A generation step streams every cell once and writes each new value
    // one row behind the read side, past the grid RAM read and window registers.
    localparam int SCAN_FEED_LAST = CELL_COUNT + GRID_WIDTH;
    localparam int SCAN_WR_FIRST  = GRID_WIDTH + 3;
    localparam int SCAN_LAST      = CELL_COUNT + GRID_WIDTH + 2;
    localparam int SCAN_W         = $clog2(SCAN_LAST + 1);

    typedef enum logic [STATE_W-1:0] {
        CELL_EMPTY = 2'd0,
        CELL_HEAD  = 2'd1,
        CELL_TAIL  = 2'd2,
        CELL_COND  = 2'd3
    } cell_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Control from the scan sequencer to the neighborhood window.
    typedef struct packed {
        logic shift;
        logic mask_top;
        logic mask_bot;
        logic mask_left;
        logic mask_right;
    } win_ctl_t;

endpackage

>>> rtl/wwgs_cmd_if.sv
// Command channel of the Wireworld grid stepper: valid, ready and one command.
// Depends on wwgs_pkg.
interface wwgs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [wwgs_pkg::KIND_W-1:0]  kind;
    logic [wwgs_pkg::COORD_W-1:0] col;
    logic [wwgs_pkg::COORD_W-1:0] row;
    logic [wwgs_pkg::STATE_W-1:0] new_state;

    modport source (output valid, output kind, output col, output row, output new_state,
                    input ready);
    modport sink (input valid, input kind, input col, input row, input new_state,
                  output ready);
endinterface

>>> rtl/wwgs_rsp_if.sv
// Response channel of the Wireworld grid stepper: valid, ready and one cell state.
// Depends on wwgs_pkg.
interface wwgs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [wwgs_pkg::STATE_W-1:0] read_state;

    modport source (output valid, output read_state, input ready);
    modport sink (input valid, input read_state, output ready);
endinterface

>>> rtl/wwgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module wwgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/wwgs_window.sv
// 3x3 neighborhood window and Wireworld update rule for the generation scan.
// Depends on wwgs_pkg.
module wwgs_window (
    input  logic               clk,
    input  wwgs_pkg::win_ctl_t ctl,
    input  wwgs_pkg::cell_t    col_top,
    input  wwgs_pkg::cell_t    col_mid,
    input  wwgs_pkg::cell_t    col_bot,
    output wwgs_pkg::cell_t    next_cell
);

    // win_reg[row][col]; column 2 holds the newest sample.
    wwgs_pkg::cell_t win_reg [3][3];
    wwgs_pkg::cell_t new_col [3];

    logic [3:0] heads;

    assign new_col[0] = col_top;
    assign new_col[1] = col_mid;
    assign new_col[2] = col_bot;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= new_col[r];
            end
        end
    end

    // Samples that fall outside the grid, or that belong to the neighboring
    // row at a left or right edge, are masked out of the head count.
    always_comb
    begin
        logic keep;
        heads = 4'd0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                keep = !(r == 1 && c == 1)
                       && !(r == 0 && ctl.mask_top)
                       && !(r == 2 && ctl.mask_bot)
                       && !(c == 0 && ctl.mask_left)
                       && !(c == 2 && ctl.mask_right);
                if (keep && win_reg[r][c] == wwgs_pkg::CELL_HEAD)
                begin
                    heads = heads + 4'd1;
                end
            end
        end
    end

    always_comb
    begin
        case (win_reg[1][1])
            wwgs_pkg::CELL_HEAD: next_cell = wwgs_pkg::CELL_TAIL;
            wwgs_pkg::CELL_TAIL: next_cell = wwgs_pkg::CELL_COND;
            wwgs_pkg::CELL_COND:
            begin
                if (heads == 4'd1 || heads == 4'd2)
                begin
                    next_cell = wwgs_pkg::CELL_HEAD;
                end
                else
                begin
                    next_cell = wwgs_pkg::CELL_COND;
                end
            end
            default: next_cell = wwgs_pkg::CELL_EMPTY;
        endcase
    end

endmodule

>>> rtl/wireworld_grid_stepper.sv
// Channel   Role   Beat contents
// cmd       sink   kind, col, row, new_state
// rsp       source read_state (cell state for reads, else 0)
//
// Read beats pass through ST_READ because of the registered grid RAM read; other beats do not.
// A clear beat holds off commands while every cell is cleared, one cell per cycle.
// A generation step holds off commands while every cell is read once, one cell read per cycle
// through the single grid read port, plus the window fill.
// After reset the same clearing pass runs with cmd.ready low.
// A command is taken only when the response register is empty or drains in that cycle.
// Top level of the Wireworld grid stepper; depends on wwgs_pkg, the channel
// interfaces, wwgs_ram and wwgs_window.
module wireworld_grid_stepper (
    input  logic      clk,
    input  logic      rst_n,
    wwgs_cmd_if.sink  cmd,
    wwgs_rsp_if.source rsp
);

    localparam int AW  = wwgs_pkg::ADDR_W;
    localparam int LAW = wwgs_pkg::COL_IDX_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP
    } state_t;

    state_t                           state_reg;
    logic                             rsp_valid_reg;
    wwgs_pkg::cell_t                  rsp_state_reg;
    logic                             rd_in_reg;
    logic [AW-1:0]                    clr_addr_reg;
    logic [wwgs_pkg::SCAN_W-1:0]      t_reg;
    logic [LAW-1:0]                   lp_reg;
    logic                             s1_v_reg;
    logic                             s1_in_reg;
    logic [LAW-1:0]                   s1_p_reg;
    logic [AW-1:0]                    wa_reg;
    logic [wwgs_pkg::ROW_IDX_W-1:0]   rc_reg;
    logic [wwgs_pkg::COL_IDX_W-1:0]   cc_reg;

    wwgs_pkg::kind_t    cmd_kind;
    logic               cmd_ready;
    logic               cmd_fire;
    logic               cmd_inside;
    logic [AW-1:0]      cmd_addr;
    logic               wr_active;

    logic               grid_we;
    logic [AW-1:0]      grid_waddr;
    logic [1:0]         grid_wdata;
    logic               grid_re;
    logic [AW-1:0]      grid_raddr;
    logic [1:0]         grid_rdata;

    logic               line_re;
    logic [3:0]         line_wdata;
    logic [3:0]         line_rdata;

    wwgs_pkg::cell_t    scan_cell;
    wwgs_pkg::cell_t    win_next;
    wwgs_pkg::win_ctl_t win_ctl;

    assign cmd_kind   = wwgs_pkg::kind_t'(cmd.kind);
    assign cmd_ready  = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cmd_fire   = cmd.valid && cmd_ready;
    assign cmd_inside = (int'(cmd.col) < wwgs_pkg::GRID_WIDTH)
                        && (int'(cmd.row) < wwgs_pkg::GRID_HEIGHT);
    assign cmd_addr   = AW'(int'(cmd.row) * wwgs_pkg::GRID_WIDTH + int'(cmd.col));

    assign cmd.ready      = cmd_ready;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_state = rsp_state_reg;

    // New cell values are written one row behind the reads, past the grid RAM read and window
    // registers, so every grid read during a step still sees the old generation.
    assign wr_active = (state_reg == ST_STEP)
                       && (int'(t_reg) >= wwgs_pkg::SCAN_WR_FIRST);

    assign scan_cell  = s1_in_reg ? wwgs_pkg::cell_t'(grid_rdata) : wwgs_pkg::CELL_EMPTY;
    assign line_re    = (state_reg == ST_STEP);
    assign line_wdata = {line_rdata[1:0], scan_cell};

    assign win_ctl.shift      = s1_v_reg;
    assign win_ctl.mask_top   = (rc_reg == '0);
    assign win_ctl.mask_bot   = (rc_reg == wwgs_pkg::ROW_IDX_W'(wwgs_pkg::GRID_HEIGHT - 1));
    assign win_ctl.mask_left  = (cc_reg == '0);
    assign win_ctl.mask_right = (cc_reg == wwgs_pkg::COL_IDX_W'(wwgs_pkg::GRID_WIDTH - 1));

    always_comb
    begin
        grid_we    = 1'b0;
        grid_waddr = wa_reg;
        grid_wdata = win_next;
        grid_re    = 1'b0;
        grid_raddr = cmd_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = clr_addr_reg;
                grid_wdata = wwgs_pkg::CELL_EMPTY;
            end
            ST_IDLE:
            begin
                if (cmd_fire && cmd_kind == wwgs_pkg::KIND_WRITE && cmd_inside)
                begin
                    grid_we    = 1'b1;
                    grid_waddr = cmd_addr;
                    grid_wdata = cmd.new_state;
                end
                grid_re = cmd_fire && cmd_kind == wwgs_pkg::KIND_READ;
            end
            ST_STEP:
            begin
                grid_we    = wr_active;
                grid_re    = int'(t_reg) < wwgs_pkg::CELL_COUNT;
                grid_raddr = t_reg[AW-1:0];
            end
            default:
            begin
                grid_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
            rsp_state_reg <= wwgs_pkg::CELL_EMPTY;
            rd_in_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            t_reg         <= '0;
            lp_reg        <= '0;
            s1_v_reg      <= 1'b0;
            s1_in_reg     <= 1'b0;
            s1_p_reg      <= '0;
            wa_reg        <= '0;
            rc_reg        <= '0;
            cc_reg        <= '0;
        end
        else
        begin
            // A non-read command taken in the draining cycle reloads the register below.
            if (rsp_valid_reg && rsp.ready
                && !(cmd_fire && cmd_kind != wwgs_pkg::KIND_READ))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(wwgs_pkg::CELL_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        // Only reads carry data; every other result is empty
                        // and is posted as soon as the command is taken.
                        if (cmd_kind != wwgs_pkg::KIND_READ)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_state_reg <= wwgs_pkg::CELL_EMPTY;
                        end
                        unique case (cmd_kind)
                            wwgs_pkg::KIND_READ:
                            begin
                                rd_in_reg <= cmd_inside;
                                state_reg <= ST_READ;
                            end
                            wwgs_pkg::KIND_STEP:
                            begin
                                t_reg     <= '0;
                                lp_reg    <= '0;
                                s1_v_reg  <= 1'b0;
                                s1_in_reg <= 1'b0;
                                wa_reg    <= '0;
                                rc_reg    <= '0;
                                cc_reg    <= '0;
                                state_reg <= ST_STEP;
                            end
                            wwgs_pkg::KIND_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                state_reg    <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_state_reg <= rd_in_reg ? wwgs_pkg::cell_t'(grid_rdata)
                                               : wwgs_pkg::CELL_EMPTY;
                    state_reg     <= ST_IDLE;
                end
                ST_STEP:
                begin
                    t_reg     <= t_reg + 1'b1;
                    s1_v_reg  <= int'(t_reg) <= wwgs_pkg::SCAN_FEED_LAST;
                    s1_in_reg <= int'(t_reg) < wwgs_pkg::CELL_COUNT;
                    s1_p_reg  <= lp_reg;
                    if (lp_reg == LAW'(wwgs_pkg::GRID_WIDTH - 1))
                    begin
                        lp_reg <= '0;
                    end
                    else
                    begin
                        lp_reg <= lp_reg + 1'b1;
                    end
                    if (wr_active)
                    begin
                        wa_reg <= wa_reg + 1'b1;
                        if (cc_reg == wwgs_pkg::COL_IDX_W'(wwgs_pkg::GRID_WIDTH - 1))
                        begin
                            cc_reg <= '0;
                            rc_reg <= rc_reg + 1'b1;
                        end
                        else
                        begin
                            cc_reg <= cc_reg + 1'b1;
                        end
                    end
                    if (int'(t_reg) == wwgs_pkg::SCAN_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    wwgs_ram #(
        .WIDTH(2),
        .DEPTH(wwgs_pkg::CELL_COUNT)
    ) u_grid_ram (
        .clk  (clk),
        .we   (grid_we),
        .waddr(grid_waddr),
        .wdata(grid_wdata),
        .re   (grid_re),
        .raddr(grid_raddr),
        .rdata(grid_rdata)
    );

    // Two-row delay line of old cell values: low pair is one row back,
    // high pair is two rows back.
    wwgs_ram #(
        .WIDTH(4),
        .DEPTH(wwgs_pkg::GRID_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (s1_v_reg),
        .waddr(s1_p_reg),
        .wdata(line_wdata),
        .re   (line_re),
        .raddr(lp_reg),
        .rdata(line_rdata)
    );

    wwgs_window u_window (
        .clk      (clk),
        .ctl      (win_ctl),
        .col_top  (wwgs_pkg::cell_t'(line_rdata[3:2])),
        .col_mid  (wwgs_pkg::cell_t'(line_rdata[1:0])),
        .col_bot  (scan_cell),
        .next_cell(win_next)
    );

endmodule

>>> rtl/wwgs_checker.sv
// Port-level assertions for the Wireworld grid stepper, bound to the top level.
// Depends on wwgs_pkg and wireworld_grid_stepper.
module wwgs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic [wwgs_pkg::KIND_W-1:0]  cmd_kind,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [wwgs_pkg::STATE_W-1:0] rsp_read_state
);

    logic cmd_beat;
    logic rd_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rd_beat  = cmd_beat && (cmd_kind == wwgs_pkg::KIND_READ);

    // A stalled response beat keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_state))
        else $error("response changed while stalled");

    // Commands other than reads answer with an empty cell right away.
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat && cmd_kind != wwgs_pkg::KIND_READ
        |=> rsp_valid && rsp_read_state == wwgs_pkg::CELL_EMPTY)
        else $error("non-read command did not post an empty result");

    // A read is answered through the ST_READ state and the response register, with no response valid in between.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rd_beat |=> !rsp_valid ##1 rsp_valid)
        else $error("read result timing wrong");

    // No command is taken while a read is in flight.
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rd_beat |=> !cmd_ready)
        else $error("command taken during read");

endmodule

bind wireworld_grid_stepper wwgs_checker u_wwgs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_kind      (cmd.kind),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_state(rsp.read_state)
);
